@@ src/pclb_pkg.sv @@
// shared types, constants and helpers for the periodic cell list binning block
// no dependencies
package pclb_pkg;

	localparam int MaxParticles = 4096;
	localparam int PnW          = $clog2(MaxParticles);
	localparam int CntW         = PnW + 1;
	localparam int MaxCells     = 16;
	localparam int CellW        = $clog2(MaxCells);
	localparam int NW           = CellW + 1;
	localparam int FlatW        = 3 * CellW;
	localparam int CellSlots    = 1 << FlatW;
	localparam int DivW         = 36;
	localparam int DivCntW      = $clog2(DivW);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_HEAD   = 2'd2;
	localparam logic [1:0] OP_NEXT   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] CFG_MIN_X  = 3'd0;
	localparam logic [2:0] CFG_MIN_Y  = 3'd1;
	localparam logic [2:0] CFG_MIN_Z  = 3'd2;
	localparam logic [2:0] CFG_SIZE_X = 3'd3;
	localparam logic [2:0] CFG_SIZE_Y = 3'd4;
	localparam logic [2:0] CFG_SIZE_Z = 3'd5;
	localparam logic [2:0] CFG_GRID   = 3'd6;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [3:0]        cell_x;
		logic [3:0]        cell_y;
		logic [3:0]        cell_z;
		logic [11:0]       particle_number;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [11:0]        particle_out;
		logic [11:0]        cell_out;
		logic signed [31:0] wrapped_x;
		logic signed [31:0] wrapped_y;
		logic signed [31:0] wrapped_z;
	} result_t;

	typedef enum logic [2:0] {
		RES_HOLD, RES_CLEAR, RES_FULL, RES_RANGE, RES_INSERT, RES_QUERY
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     swp_init;
		logic     swp_step;
		logic     mod_init;
		logic     div_step;
		logic     bin_init;
		logic     axis_end;
		logic     flat_ld;
		logic     ins_wr;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       full;
		logic       bad;
		logic       div_last;
		logic       axis_last;
		logic       swp_last;
	} stat_t;

	// zero count acts as one, oversize count saturates
	function automatic logic [NW-1:0] axis_count(input logic [4:0] f);
		logic [NW-1:0] n;
		if (f == 5'd0) n = NW'(1);
		else if (32'(f) > MaxCells) n = NW'(MaxCells);
		else n = NW'(f);
		return n;
	endfunction

endpackage

@@ src/pclb_dp.sv @@
// datapath: config registers, shared serial divider, tables and result register
// depends on pclb_pkg
module pclb_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  pclb_pkg::item_t  item,
	input  logic             cfg_valid,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  pclb_pkg::cmd_t   cmd,
	output pclb_pkg::stat_t  stat,
	output pclb_pkg::result_t result
);
	import pclb_pkg::*;

	logic signed [31:0] min_q [3];
	logic [30:0]        size_q [3];
	logic [14:0]        grid_q;

	item_t              item_q;
	logic [CellW-1:0]   c_q [3];
	logic [1:0]         axis_q;
	logic signed [31:0] w_q [3];
	logic [DivW-1:0]    dvd_q;
	logic [30:0]        rem_q;
	logic [4:0]         quo_q;
	logic [DivCntW-1:0] dcnt_q;
	logic [FlatW-1:0]   flat_q;
	logic [CntW-1:0]    count_q;
	logic [FlatW-1:0]   swp_q;
	result_t            res_q;
	result_t            res_d;

	logic [PnW:0]   heads_mem [CellSlots];
	logic [PnW-1:0] tails_mem [CellSlots];
	logic [PnW:0]   links_mem [MaxParticles];
	logic [PnW:0]   head_rd_q, link_rd_q;
	logic [PnW-1:0] tail_rd_q;

	logic [NW-1:0] n [3];
	logic signed [31:0] p, mn;
	logic [30:0]        s;
	logic [NW-1:0]      na;
	logic signed [33:0] p_e, mn_e, mx_e, diff;
	logic               below, above;
	logic [32:0]        mod_dvd;
	logic [31:0]        t, tsub;
	logic               ge;
	logic [30:0]        d;
	logic [DivW-1:0]    prod;
	logic [CellW-1:0]   cbin;
	logic [2*NW-1:0]    nxy;
	logic [FlatW:0]     flat_full;

	always_comb begin
		for (int a = 0; a < 3; a++) n[a] = axis_count(grid_q[5*a +: 5]);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a]  <= '0;
				size_q[a] <= 31'd1048576;
			end
			grid_q <= 15'd16912;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_X:  min_q[0] <= cfg_data;
				CFG_MIN_Y:  min_q[1] <= cfg_data;
				CFG_MIN_Z:  min_q[2] <= cfg_data;
				CFG_SIZE_X: size_q[0] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
				CFG_SIZE_Y: size_q[1] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
				CFG_SIZE_Z: size_q[2] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
				CFG_GRID:   grid_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// per-axis wrap arithmetic
	always_comb begin
		unique case (axis_q)
			2'd0:    begin p = item_q.pos_x; mn = min_q[0]; s = size_q[0]; na = n[0]; end
			2'd1:    begin p = item_q.pos_y; mn = min_q[1]; s = size_q[1]; na = n[1]; end
			default: begin p = item_q.pos_z; mn = min_q[2]; s = size_q[2]; na = n[2]; end
		endcase
		p_e     = 34'(p);
		mn_e    = 34'(mn);
		mx_e    = mn_e + {3'b000, s};
		diff    = p_e - mn_e;
		below   = p_e < mn_e;
		above   = p_e > mx_e;
		mod_dvd = below ? 33'(-diff) : diff[32:0];
		t       = {rem_q, dvd_q[DivW-1]};
		tsub    = t - {1'b0, s};
		ge      = t >= {1'b0, s};
		if (below) d = s - rem_q;
		else if (above) d = rem_q;
		else d = diff[30:0];
		prod    = DivW'({5'b0, d} * {31'b0, na});
		cbin    = (quo_q >= na) ? CellW'(na - NW'(1)) : CellW'(quo_q);
		nxy     = n[0] * n[1];
		flat_full = (FlatW+1)'(c_q[0]) + (FlatW+1)'(n[0] * c_q[1])
			+ (FlatW+1)'(nxy * c_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= '0;
			dcnt_q  <= '0;
			count_q <= '0;
			swp_q   <= '0;
		end else begin
			if (cmd.load) axis_q <= '0;
			else if (cmd.axis_end) axis_q <= axis_q + 2'd1;
			if (cmd.mod_init || cmd.bin_init) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DivCntW'(1);
			if (cmd.swp_init) count_q <= '0;
			else if (cmd.ins_wr) count_q <= count_q + CntW'(1);
			if (cmd.swp_init) swp_q <= '0;
			else if (cmd.swp_step) swp_q <= swp_q + FlatW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			c_q[0] <= item.cell_x;
			c_q[1] <= item.cell_y;
			c_q[2] <= item.cell_z;
		end else if (cmd.axis_end) begin
			c_q[axis_q] <= cbin;
		end
		if (cmd.mod_init) begin
			dvd_q <= DivW'(mod_dvd);
			rem_q <= '0;
		end else if (cmd.bin_init) begin
			dvd_q     <= prod;
			rem_q     <= '0;
			w_q[axis_q] <= mn + 32'(d);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DivW-2:0], 1'b0};
			rem_q <= ge ? tsub[30:0] : t[30:0];
			quo_q <= {quo_q[3:0], ge};
		end
		if (cmd.flat_ld) flat_q <= flat_full[FlatW-1:0];
	end

	// tables
	always_ff @(posedge clk) begin
		if (cmd.swp_step) heads_mem[swp_q] <= '0;
		else if (cmd.ins_wr && !head_rd_q[PnW]) heads_mem[flat_q] <= {1'b1, count_q[PnW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_wr) tails_mem[flat_q] <= count_q[PnW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.swp_step) links_mem[swp_q] <= '0;
		else if (cmd.ins_wr && head_rd_q[PnW]) links_mem[tail_rd_q] <= {1'b1, count_q[PnW-1:0]};
	end

	always_ff @(posedge clk) begin
		head_rd_q <= heads_mem[flat_q];
		tail_rd_q <= tails_mem[flat_q];
		link_rd_q <= links_mem[item_q.particle_number];
	end

	// next result word, unused fields stay zero
	always_comb begin
		res_d = '0;
		unique case (cmd.res_sel)
			RES_FULL:  res_d.status = ST_FULL;
			RES_RANGE: res_d.status = ST_RANGE;
			RES_INSERT: begin
				res_d.particle_out = count_q[PnW-1:0];
				res_d.cell_out     = flat_q;
				res_d.wrapped_x    = w_q[0];
				res_d.wrapped_y    = w_q[1];
				res_d.wrapped_z    = w_q[2];
			end
			RES_QUERY: begin
				if (item_q.opcode == OP_HEAD) begin
					res_d.cell_out     = flat_q;
					res_d.found        = head_rd_q[PnW];
					res_d.particle_out = head_rd_q[PnW] ? head_rd_q[PnW-1:0] : '0;
				end else begin
					res_d.found        = link_rd_q[PnW];
					res_d.particle_out = link_rd_q[PnW] ? link_rd_q[PnW-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_sel != RES_HOLD) res_q <= res_d;
	end

	always_comb begin
		stat.opcode    = item_q.opcode;
		stat.full      = count_q == CntW'(MaxParticles);
		stat.bad       = (item_q.opcode == OP_HEAD)
			? (NW'(c_q[0]) >= n[0] || NW'(c_q[1]) >= n[1] || NW'(c_q[2]) >= n[2])
			: ({1'b0, item_q.particle_number} >= count_q);
		stat.div_last  = dcnt_q == DivCntW'(DivW - 1);
		stat.axis_last = axis_q == 2'd2;
		stat.swp_last  = &swp_q;
	end

	assign result = res_q;

endmodule

@@ src/pclb_ctrl.sv @@
// controller state machine sequencing the datapath
// depends on pclb_pkg
module pclb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pclb_pkg::stat_t stat,
	output pclb_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            result_valid
);
	import pclb_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_CLEAR    = 14'b00000000000010,
		S_CHECK    = 14'b00000000000100,
		S_MOD_INIT = 14'b00000000001000,
		S_MOD      = 14'b00000000010000,
		S_BIN_INIT = 14'b00000000100000,
		S_BIN      = 14'b00000001000000,
		S_AXIS_END = 14'b00000010000000,
		S_FLAT     = 14'b00000100000000,
		S_RD       = 14'b00001000000000,
		S_WR       = 14'b00010000000000,
		S_QRD      = 14'b00100000000000,
		S_QRES     = 14'b01000000000000,
		S_OUT      = 14'b10000000000000
	} state_t;

	state_t state_q, nxt;
	logic   clr_op_q;

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_HOLD;
		nxt         = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					nxt      = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.opcode == OP_CLEAR) begin
					cmd.swp_init = 1'b1;
					nxt          = S_CLEAR;
				end else if (stat.opcode == OP_INSERT) begin
					if (stat.full) begin
						cmd.res_sel = RES_FULL;
						nxt         = S_OUT;
					end else begin
						nxt = S_MOD_INIT;
					end
				end else begin
					cmd.flat_ld = 1'b1;
					if (stat.bad) begin
						cmd.res_sel = RES_RANGE;
						nxt         = S_OUT;
					end else begin
						nxt = S_QRD;
					end
				end
			end
			S_CLEAR: begin
				cmd.swp_step = 1'b1;
				if (stat.swp_last) begin
					if (clr_op_q) begin
						cmd.res_sel = RES_CLEAR;
						nxt         = S_OUT;
					end else begin
						nxt = S_IDLE;
					end
				end
			end
			S_MOD_INIT: begin
				cmd.mod_init = 1'b1;
				nxt          = S_MOD;
			end
			S_MOD: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) nxt = S_BIN_INIT;
			end
			S_BIN_INIT: begin
				cmd.bin_init = 1'b1;
				nxt          = S_BIN;
			end
			S_BIN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) nxt = S_AXIS_END;
			end
			S_AXIS_END: begin
				cmd.axis_end = 1'b1;
				nxt          = stat.axis_last ? S_FLAT : S_MOD_INIT;
			end
			S_FLAT: begin
				cmd.flat_ld = 1'b1;
				nxt         = S_RD;
			end
			S_RD: nxt = S_WR;
			S_WR: begin
				cmd.ins_wr  = 1'b1;
				cmd.res_sel = RES_INSERT;
				nxt         = S_OUT;
			end
			S_QRD: nxt = S_QRES;
			S_QRES: begin
				cmd.res_sel = RES_QUERY;
				nxt         = S_OUT;
			end
			S_OUT: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_op_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (state_q == S_CHECK && stat.opcode == OP_CLEAR) clr_op_q <= 1'b1;
			else if (state_q == S_CLEAR && stat.swp_last) clr_op_q <= 1'b0;
		end
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = state_q == S_OUT;

endmodule

@@ src/periodic_cell_list_binning.sv @@
// top level of the periodic linked cell list binning block
// depends on pclb_pkg, pclb_ctrl, pclb_dp
//
// One word is taken per command: start is accepted when busy is low, and the
// result word shows on result for exactly one cycle with result_valid high;
// the receiver cannot stall it, so capture it on that cycle. After reset the
// block runs a clearing pass over the 4096-entry cell and link tables, one
// entry a cycle with busy high; a clear command runs the same pass, also with
// busy high. During an insert each axis runs a 36-step modulo and a 36-step
// binning divide on one shared serial divider, with a setup state before each
// and a state to store the cell, plus states to check the command, form the
// cell index, read the cell's head and tail entries, write the new head or link
// entry and show the result. Head and next queries pass through check, table
// read, result and output states, a rejected insert or query through check and
// output only; the result strobe is the last busy cycle.
// Config writes are always ready but must only be issued while busy is low.
module periodic_cell_list_binning (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pclb_pkg::item_t   item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              result_valid,
	output pclb_pkg::result_t result
);
	import pclb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// config registers live in the datapath and take a word every cycle
	assign cfg_ready = 1'b1;

	pclb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	pclb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// an accepted command always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// a result word is never shown while idle
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// the result strobe is a single cycle and is followed by idle
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> (!result_valid && !busy))
		else $error("result strobe longer than one cycle");
`endif

endmodule

@@ tb/periodic_cell_list_binning_tb.sv @@
// testbench for periodic_cell_list_binning: directed and random commands checked
// against a behavioral model of the binning tables; depends on pclb_pkg and the rtl
`timescale 1ns / 1ps

module periodic_cell_list_binning_tb;
	import pclb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 25000000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic    result_valid;
	result_t result;

	periodic_cell_list_binning dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .result(result)
	);

	// model of the box registers and the cell tables
	longint      box_lo [3];
	longint      box_ext [3];
	logic [14:0] grid_cfg;
	logic [12:0] head_tab [MaxParticles];  // bit 12 marks a valid entry
	logic [12:0] link_tab [MaxParticles];
	int unsigned n_particles;

	result_t     expected_words [$];
	int unsigned n_errors;
	int unsigned n_cycles;
	bit          no_gaps;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int unsigned axis_cells(int a);
		logic [4:0] f;
		f = grid_cfg[5*a +: 5];
		if (f == 5'd0) return 1;
		if (f > 5'd16) return 16;
		return 32'(f);
	endfunction

	function automatic void wipe_tables();
		for (int i = 0; i < MaxParticles; i++) begin
			head_tab[i] = '0;
			link_tab[i] = '0;
		end
		n_particles = 0;
	endfunction

	// periodic wrap on one axis, cell index out through c
	function automatic longint wrap_coord(int a, longint p, output int unsigned c);
		longint mn, s, mx, w;
		longint unsigned q;
		int unsigned n;
		mn = box_lo[a];
		s = box_ext[a];
		mx = mn + s;
		n = axis_cells(a);
		w = p;
		if (p < mn) w = mx - ((mn - p) % s);
		else if (p > mx) w = mn + ((p - mn) % s);
		q = (longint'(w - mn) * n) / s;
		if (q >= n) q = n - 1;   // upper face clamps to the last cell
		c = 32'(q);
		return w;
	endfunction

	function automatic result_t bin_word(item_t it);
		result_t r;
		int unsigned nx, ny, nz, flat, t, steps;
		int unsigned c [3];
		longint w [3];
		r = '0;
		nx = axis_cells(0);
		ny = axis_cells(1);
		nz = axis_cells(2);
		case (it.opcode)
			OP_CLEAR: wipe_tables();
			OP_INSERT: begin
				if (n_particles >= MaxParticles) begin
					r.status = ST_FULL;
				end else begin
					w[0] = wrap_coord(0, longint'(it.pos_x), c[0]);
					w[1] = wrap_coord(1, longint'(it.pos_y), c[1]);
					w[2] = wrap_coord(2, longint'(it.pos_z), c[2]);
					flat = c[0] + nx * c[1] + nx * ny * c[2];
					if (head_tab[flat][12]) begin
						// walk to the tail of the chain
						t = head_tab[flat][11:0];
						steps = 0;
						while (link_tab[t][12] && steps < MaxParticles) begin
							t = link_tab[t][11:0];
							steps++;
						end
						link_tab[t] = {1'b1, 12'(n_particles)};
					end else begin
						head_tab[flat] = {1'b1, 12'(n_particles)};
					end
					r.particle_out = 12'(n_particles);
					r.cell_out = 12'(flat);
					r.wrapped_x = w[0][31:0];
					r.wrapped_y = w[1][31:0];
					r.wrapped_z = w[2][31:0];
					n_particles++;
				end
			end
			OP_HEAD: begin
				if (it.cell_x >= nx || it.cell_y >= ny || it.cell_z >= nz) begin
					r.status = ST_RANGE;
				end else begin
					flat = it.cell_x + nx * it.cell_y + nx * ny * it.cell_z;
					r.cell_out = 12'(flat);
					if (head_tab[flat][12]) begin
						r.found = 1'b1;
						r.particle_out = head_tab[flat][11:0];
					end
				end
			end
			default: begin
				if (it.particle_number >= n_particles) begin
					r.status = ST_RANGE;
				end else if (link_tab[it.particle_number][12]) begin
					r.found = 1'b1;
					r.particle_out = link_tab[it.particle_number][11:0];
				end
			end
		endcase
		return r;
	endfunction

	// result checker: each strobed word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				n_errors++;
			end else begin
				result_t e;
				e = expected_words.pop_front();
				if (e.status !== result.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, result.status);
				if (e.found !== result.found)
					$display("%0t: found exp %0d got %0d", $time, e.found, result.found);
				if (e.particle_out !== result.particle_out)
					$display("%0t: particle exp %0d got %0d", $time, e.particle_out,
						result.particle_out);
				if (e.cell_out !== result.cell_out)
					$display("%0t: cell exp %0d got %0d", $time, e.cell_out, result.cell_out);
				if (e.wrapped_x !== result.wrapped_x)
					$display("%0t: wx exp %h got %h", $time, e.wrapped_x, result.wrapped_x);
				if (e.wrapped_y !== result.wrapped_y)
					$display("%0t: wy exp %h got %h", $time, e.wrapped_y, result.wrapped_y);
				if (e.wrapped_z !== result.wrapped_z)
					$display("%0t: wz exp %h got %h", $time, e.wrapped_z, result.wrapped_z);
				if (e !== result) n_errors++;
			end
		end
	end

	// send one command word; start stays high when the next word follows at once
	task automatic send_word(item_t it);
		int unsigned gap;
		result_t exp_word;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		exp_word = bin_word(it);
		expected_words = {expected_words, exp_word};
	endtask

	// drop start and let every pending word come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// valid stays high across back-to-back writes; the caller drops it
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		if (idx <= CFG_MIN_Z) box_lo[idx] = longint'($signed(data));
		else if (idx <= CFG_SIZE_Z) box_ext[idx - 3] = (data[30:0] == 0) ? 1 : data[30:0];
		else grid_cfg = data[14:0];
	endtask

	task automatic set_box(logic [31:0] mn, logic [31:0] sz, logic [14:0] g);
		write_reg(CFG_MIN_X, mn);
		write_reg(CFG_MIN_Y, mn);
		write_reg(CFG_MIN_Z, mn);
		write_reg(CFG_SIZE_X, sz);
		write_reg(CFG_SIZE_Y, sz);
		write_reg(CFG_SIZE_Z, sz);
		write_reg(CFG_GRID, {17'd0, g});
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t make_word(logic [1:0] op, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		item_t it;
		it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom, $urandom}));
		it.opcode = op;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		return it;
	endfunction

	task automatic query_head(logic [3:0] cx, logic [3:0] cy, logic [3:0] cz);
		item_t it;
		it = make_word(OP_HEAD, $urandom, $urandom, $urandom);
		it.cell_x = cx;
		it.cell_y = cy;
		it.cell_z = cz;
		send_word(it);
	endtask

	task automatic query_next(logic [11:0] pn);
		item_t it;
		it = make_word(OP_NEXT, $urandom, $urandom, $urandom);
		it.particle_number = pn;
		send_word(it);
	endtask

	// coordinate drawn near the box of one axis, sometimes anywhere
	function automatic logic [31:0] rand_coord(int a);
		longint v;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return box_lo[a][31:0];
			2: return 32'(box_lo[a] + box_ext[a]);
			default: begin
				v = box_lo[a] + longint'($urandom_range(0, 3 * 65536)) * box_ext[a] / 65536
					- box_ext[a];
				return v[31:0];
			end
		endcase
	endfunction

	// directed: reset box, extremes of positions, all opcodes
	task automatic test_reset_box();
		send_word(make_word(OP_INSERT, 32'h0, 32'h0, 32'h0));
		send_word(make_word(OP_INSERT, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000)); // face
		send_word(make_word(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
		send_word(make_word(OP_INSERT, 32'h0, 32'h0, 32'h0));        // same cell, chains
		send_word(make_word(OP_INSERT, 32'h0020_0000, 32'h0030_0001, 32'hfff0_0000));
		query_head(4'd0, 4'd0, 4'd0);
		query_head(4'd15, 4'd15, 4'd15);
		query_next(12'd0);
		query_next(12'd3);
		query_next(12'd5);      // unknown particle
		query_next(12'hfff);
		send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom));
		query_head(4'd0, 4'd0, 4'd0);
		query_next(12'd0);
		drain();
	endtask

	// directed: odd grid counts, zero size, extreme and wide boxes
	task automatic test_box_extremes();
		set_box(32'h8000_0000, 32'h7fff_ffff, 15'h7fff);  // counts saturate
		send_word(make_word(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
		send_word(make_word(OP_INSERT, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff));
		drain();
		set_box(32'h7fff_0000, 32'h8000_0000, 15'd0);     // zero size, one cell per axis
		send_word(make_word(OP_INSERT, 32'h7fff_0000, 32'h0, 32'h8000_0000));
		query_head(4'd0, 4'd0, 4'd0);
		query_head(4'd1, 4'd0, 4'd0);
		query_head(4'd0, 4'd0, 4'd1);
		drain();
		set_box(32'h7fff_0000, 32'h7fff_ffff, {5'd3, 5'd17, 5'd2}); // wide box
		send_word(make_word(OP_INSERT, 32'h8000_0000, 32'h0, 32'h7fff_ffff));
		send_word(make_word(OP_INSERT, 32'h7fff_ffff, 32'h8000_0001, 32'h1));
		query_head(4'd1, 4'd15, 4'd2);
		query_head(4'd2, 4'd0, 4'd0);
		query_head(4'd0, 4'd0, 4'd3);
		query_next(12'd1);
		drain();
	endtask

	// random phases, each with its own box and grid
	task automatic test_random_phases();
		item_t it;
		int unsigned r;
		for (int ph = 0; ph < 10; ph++) begin
			no_gaps = (ph % 4 == 3);
			for (int i = 0; i < 7; i++) begin
				r = $urandom;
				if (i == 6) r[14:0] = {5'($urandom_range(0, 5)), 5'($urandom_range(0, 17)),
					5'($urandom_range(1, 16))};
				else if (i >= 3 && $urandom_range(0, 3) != 0) r = $urandom_range(1, 32'h0040_0000);
				else if (i < 3 && $urandom_range(0, 2) != 0) r = 32'($signed($urandom_range(0,
					32'h0020_0000)) - 32'sh0010_0000);
				write_reg(3'(i), r);
			end
			cfg_valid <= 1'b0;
			if ($urandom_range(0, 1)) send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom));
			for (int i = 0; i < 105; i++) begin
				r = $urandom_range(0, 19);
				if (r < 10) begin
					send_word(make_word(OP_INSERT, rand_coord(0), rand_coord(1), rand_coord(2)));
				end else if (r < 14) begin
					it = make_word(OP_HEAD, $urandom, $urandom, $urandom);
					if ($urandom_range(0, 3) != 0) begin
						it.cell_x = 4'($urandom_range(0, axis_cells(0) - 1));
						it.cell_y = 4'($urandom_range(0, axis_cells(1) - 1));
						it.cell_z = 4'($urandom_range(0, axis_cells(2) - 1));
					end
					send_word(it);
				end else if (r < 19) begin
					query_next((n_particles > 0 && $urandom_range(0, 4) != 0) ?
						12'($urandom_range(0, n_particles - 1)) : 12'($urandom));
				end else begin
					send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom));
				end
				if (i == 50 && ph == 2) drain();  // sender waits for every result
			end
			drain();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errors = 0;
		n_cycles = 0;
		no_gaps = 1'b0;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = 0;
			box_ext[a] = 1048576;
		end
		grid_cfg = 15'd16912;
		wipe_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_box();
		test_box_extremes();
		test_random_phases();

		drain();
		repeat (300) @(posedge clk);
		if (n_errors == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
